[hdl/rcw_pkg.sv]
package rcw_pkg;

   localparam int MapSide    = 8;
   localparam int MarchSteps = 1000;

   // csr register indexes
   localparam logic [2:0] CSR_CAM_X      = 3'd0;
   localparam logic [2:0] CSR_CAM_Y      = 3'd1;
   localparam logic [2:0] CSR_CAM_ANGLE  = 3'd2;
   localparam logic [2:0] CSR_MAP_LOW    = 3'd3;
   localparam logic [2:0] CSR_MAP_HIGH   = 3'd4;
   localparam logic [2:0] CSR_VIEW_W     = 3'd5;
   localparam logic [2:0] CSR_VIEW_H     = 3'd6;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture column, compute offset
      logic div_start;  // start offset divider
      logic trig;       // ray angle and direction
      logic march;      // one march step
      logic hit;        // march stopped before the step limit
      logic dq_calc;    // corrected distance product
      logic hdiv_start; // start height divider
      logic finish;     // form span, load output
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic div_done;
      logic stop;       // march ends this step
      logic hdiv_done;
   } sts_type;

   // quarter-wave sine table, Q1.14
   function automatic logic [14:0] qsin(input logic [5:0] i);
      logic [14:0] v;
      begin
         case (i)
            6'd0:  v = 15'd0;     6'd1:  v = 15'd804;   6'd2:  v = 15'd1606;
            6'd3:  v = 15'd2404;  6'd4:  v = 15'd3196;  6'd5:  v = 15'd3981;
            6'd6:  v = 15'd4756;  6'd7:  v = 15'd5520;  6'd8:  v = 15'd6270;
            6'd9:  v = 15'd7005;  6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
            6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
            6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
            6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
            6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
            6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
            6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
            6'd30: v = 15'd16305; 6'd31: v = 15'd16364;
            default: v = 15'd16384;
         endcase
         return v;
      end
   endfunction

   // signed Q1.14 sine of a 12-bit angle
   function automatic logic signed [15:0] sin14(input logic [11:0] a);
      logic [1:0]  q;
      logic [10:0] r;
      logic [5:0]  idx;
      logic [4:0]  frac;
      logic [14:0] lo;
      logic [14:0] hi;
      logic [19:0] prod;
      logic [14:0] v;
      begin
         q = a[11:10];
         r = q[0] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
         idx = r[10:5];
         frac = r[4:0];
         lo = qsin(idx);
         hi = qsin(idx + 6'd1);
         prod = 20'((hi - lo) * frac) + 20'd16;
         v = (idx >= 6'd32) ? 15'd16384 : lo + 15'(prod[19:5]);
         return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
      end
   endfunction

endpackage

[hdl/rcw_if.sv]
interface rcw_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] column;
   modport source (output valid, output column, input ready);
   modport sink (input valid, input column, output ready);
endinterface

interface rcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  out_column;
   logic [1:0]  wall_code;
   logic [9:0]  span_top;
   logic [10:0] span_bottom;
   logic [9:0]  march_steps;
   modport source (output valid, output out_column, output wall_code, output span_top,
                   output span_bottom, output march_steps, input ready);
   modport sink (input valid, input out_column, input wall_code, input span_top,
                 input span_bottom, input march_steps, output ready);
endinterface

[hdl/rcw_div.sv]
// restoring divider, one quotient bit per cycle, unsigned
module rcw_div #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[W-1]} - {1'b0, den_ff};
      if (start) begin
         rem_in = '0; quo_in = num; den_in = den;
         cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;
endmodule

[hdl/rcw_ctrl.sv]
// sequencer for one column
module rcw_ctrl #(
   parameter int MARCH_STEPS = rcw_pkg::MarchSteps
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  rcw_pkg::sts_type sts,
   output rcw_pkg::cmd_type cmd,
   output logic [12:0]      step_k
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_ODIV  = 8'b00000010,
      S_TRIG  = 8'b00000100,
      S_MARCH = 8'b00001000,
      S_DIST  = 8'b00010000,
      S_HDIV  = 8'b00100000,
      S_FIN   = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type   state_ff, state_in;
   logic [12:0] k_ff, k_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign step_k = k_ff;

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1; cmd.div_start = 1'b1; state_in = S_ODIV;
            end
         end
         S_ODIV: if (sts.div_done) begin
            state_in = S_TRIG;
         end
         S_TRIG: begin
            cmd.trig = 1'b1; k_in = '0; state_in = S_MARCH;
         end
         S_MARCH: begin
            if (k_ff == 13'(MARCH_STEPS) || sts.stop) begin
               // the position at the step limit is never checked
               cmd.hit = (k_ff != 13'(MARCH_STEPS));
               state_in = S_DIST;
            end else begin
               cmd.march = 1'b1; k_in = k_ff + 13'd1;
            end
         end
         S_DIST: begin
            cmd.dq_calc = 1'b1; state_in = S_HDIV;
         end
         S_HDIV: begin
            cmd.hdiv_start = 1'b1; state_in = S_FIN;
         end
         S_FIN: if (sts.hdiv_done) begin
            cmd.finish = 1'b1; state_in = S_OUT;
         end
         S_OUT: if (rsp_ready) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

[hdl/rcw_dp.sv]
// column datapath: offset, direction, march, distance, height
module rcw_dp #(
   parameter int MAP_SIDE = rcw_pkg::MapSide
) (
   input  logic             clock,
   input  logic             reset,
   input  rcw_pkg::cmd_type cmd,
   output rcw_pkg::sts_type sts,
   input  logic [12:0]      step_k,
   input  logic [9:0]       column,
   input  logic [14:0]      cam_x,
   input  logic [14:0]      cam_y,
   input  logic [11:0]      cam_angle,
   input  logic [127:0]     map_bits,
   input  logic [10:0]      view_w,
   input  logic [10:0]      view_h,
   output logic [9:0]       out_column,
   output logic [1:0]       wall_code,
   output logic [9:0]       span_top,
   output logic [10:0]      span_bottom,
   output logic [9:0]       march_steps
);
   // h*16*327680 needs 34 bits for an 11-bit height
   localparam int HW = 36;

   logic [9:0]  col_ff;
   logic [10:0] w_sel, h_ff;
   logic        neg_ff;
   logic [31:0] onum, oquo;
   logic [HW-1:0] hnum, hquo;
   logic        odone, hdone;
   logic [11:0] offu;
   logic signed [15:0] dx_ff, dy_ff, coff_ff;
   // running k*dir sums and floor(/40) tracked incrementally
   logic signed [24:0] qx_ff, qy_ff;   // floor(k*d/40)
   logic [5:0]  rx_ff, ry_ff;          // remainder 0..39
   logic signed [15:0] sxq, syq;       // floor(d/40) per step
   logic [5:0]  sxr, syr;              // matching remainder
   logic [1:0]  code_ff;
   logic signed [31:0] dq_ff;
   logic        small_ff;
   logic signed [25:0] px, py;
   logic [1:0]  map_code;
   logic [6:0]  bitpos;
   logic        out_map;
   logic [22:0] h16;
   logic [22:0] whq;

   // floor(d/40) and remainder; 1/5 as 52429/2^18 is exact up to 2048
   function automatic void split40(input logic signed [15:0] d,
                                   output logic signed [15:0] qo, output logic [5:0] ro);
      logic [14:0] mag;
      logic [27:0] prod;
      logic [9:0]  qa;
      logic [14:0] ra;
      begin
         mag = d[15] ? 15'(-d) : d[14:0];
         prod = 28'(mag[14:3]) * 28'd52429;
         qa = prod[27:18];
         ra = mag - 15'({qa, 5'd0}) - 15'({qa, 3'd0});
         if (!d[15]) begin
            qo = $signed({6'd0, qa}); ro = ra[5:0];
         end else if (ra == 15'd0) begin
            qo = -$signed({6'd0, qa}); ro = 6'd0;
         end else begin
            qo = -$signed({6'd0, qa}) - 16'sd1; ro = 6'(15'd40 - ra);
         end
      end
   endfunction

   // step of floor(k*d/40): add quotient and remainder, carry by 40
   function automatic void adv(input logic signed [24:0] q, input logic [5:0] r,
                               input logic signed [15:0] dq40, input logic [5:0] dr,
                               output logic signed [24:0] qo, output logic [5:0] ro);
      logic [6:0] rr;
      begin
         rr = 7'(r) + 7'(dr);
         if (rr >= 7'd40) begin
            qo = q + 25'(dq40) + 25'sd1; ro = 6'(rr - 7'd40);
         end else begin
            qo = q + 25'(dq40); ro = rr[5:0];
         end
      end
   endfunction

   // zero width counts as one
   assign w_sel = (view_w == 11'd0) ? 11'd1 : view_w;

   rcw_div #(.W(32)) u_odiv (.clock(clock), .reset(reset), .start(cmd.div_start),
      .num(onum), .den({21'd0, w_sel}), .done(odone), .quo(oquo));

   // offset numerator magnitude
   always_comb begin
      logic signed [12:0] nn;
      nn = $signed({2'b0, column, 1'b0}) - $signed({2'b0, w_sel});
      onum = {10'd0, 13'(nn[12] ? -nn : nn), 9'd0};
   end

   assign offu = neg_ff ? 12'(-oquo[11:0]) : oquo[11:0];

   rcw_div #(.W(HW)) u_hdiv (.clock(clock), .reset(reset), .start(cmd.hdiv_start),
      .num(hnum), .den({4'd0, dq_ff}), .done(hdone), .quo(hquo));
   assign hnum = HW'(h_ff) * HW'(5242880);

   // per-step increments of the ray direction
   always_comb begin
      split40(dx_ff, sxq, sxr);
      split40(dy_ff, syq, syr);
   end

   // current ray position and cell
   assign px = 26'(cam_x) + 26'(qx_ff);
   assign py = 26'(cam_y) + 26'(qy_ff);
   assign out_map = px[25] || py[25] || (px[25:12] >= 14'(MAP_SIDE))
                    || (py[25:12] >= 14'(MAP_SIDE));
   assign bitpos = {py[14:12], px[14:12], 1'b0};
   assign map_code = map_bits[bitpos +: 2];

   assign sts.div_done = odone;
   assign sts.hdiv_done = hdone;
   assign sts.stop = out_map || (map_code != 2'd0);

   assign h16 = {8'd0, h_ff, 4'd0};
   always_comb begin
      logic [HW-1:0] wq;
      wq = small_ff ? HW'(h16) : hquo;
      whq = (wq >= HW'(h16)) ? h16 - 23'd16 : wq[22:0];
   end

   always_ff @(posedge clock) begin
      logic signed [24:0] nqx, nqy;
      logic [5:0] nrx, nry;
      if (cmd.load) begin
         col_ff <= column;
         h_ff <= (view_h == 11'd0) ? 11'd1 : view_h;
         neg_ff <= ($signed({2'b0, column, 1'b0}) < $signed({2'b0, w_sel}));
      end
      if (cmd.trig) begin
         dx_ff <= rcw_pkg::sin14(cam_angle + offu + 12'd1024);
         dy_ff <= rcw_pkg::sin14(cam_angle + offu);
         coff_ff <= rcw_pkg::sin14(offu + 12'd1024);
         qx_ff <= '0; qy_ff <= '0; rx_ff <= '0; ry_ff <= '0; code_ff <= '0;
      end
      if (cmd.march) begin
         adv(qx_ff, rx_ff, sxq, sxr, nqx, nrx);
         adv(qy_ff, ry_ff, syq, syr, nqy, nry);
         qx_ff <= nqx; rx_ff <= nrx; qy_ff <= nqy; ry_ff <= nry;
      end
      // latch code when the march stops on a wall
      if (cmd.hit && !out_map) code_ff <= map_code;
      if (cmd.dq_calc) begin
         dq_ff <= 32'($signed({19'd0, step_k}) * coff_ff);
      end
      small_ff <= (dq_ff < 32'sd164);
      if (cmd.finish) begin
         out_column <= col_ff;
         wall_code <= code_ff;
         span_top <= 10'((h16 - whq) >> 5);
         span_bottom <= (((h16 + whq) >> 5) > 23'(h_ff)) ? h_ff : 11'((h16 + whq) >> 5);
         march_steps <= step_k[9:0];
      end
   end
endmodule

[hdl/raycast_wall_column.sv]
// Channel | Dir | Payload
// req     | in  | column
// rsp     | out | out_column, wall_code, span_top, span_bottom, march_steps
// csr     | in  | csr_we, csr_index, csr_wdata (64b)
// One column at a time: the offset divide, the trig state, the march (k steps,
// up to MARCH_STEPS), the distance state, the height divider start and the
// height divide, after which the result is registered and offered on rsp.
// Synchronous active-high reset restores the register defaults.
// A waiting result holds until taken; no new word is accepted meanwhile.
module raycast_wall_column #(
   parameter int MAP_SIDE    = rcw_pkg::MapSide,
   parameter int MARCH_STEPS = rcw_pkg::MarchSteps
) (
   input  logic        clock,
   input  logic        reset,
   rcw_req_if.sink     req,
   rcw_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   logic [14:0]  cx_ff, cy_ff;
   logic [11:0]  ca_ff;
   logic [63:0]  ml_ff, mh_ff;
   logic [10:0]  vw_ff, vh_ff;
   rcw_pkg::cmd_type cmd;
   rcw_pkg::sts_type sts;
   logic [12:0]  k;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= 15'd6144; cy_ff <= 15'd6144; ca_ff <= '0;
         ml_ff <= '0; mh_ff <= '0; vw_ff <= 11'd320; vh_ff <= 11'd300;
      end else if (csr_we) begin
         unique case (csr_index)
            rcw_pkg::CSR_CAM_X:     cx_ff <= csr_wdata[14:0];
            rcw_pkg::CSR_CAM_Y:     cy_ff <= csr_wdata[14:0];
            rcw_pkg::CSR_CAM_ANGLE: ca_ff <= csr_wdata[11:0];
            rcw_pkg::CSR_MAP_LOW:   ml_ff <= csr_wdata;
            rcw_pkg::CSR_MAP_HIGH:  mh_ff <= csr_wdata;
            rcw_pkg::CSR_VIEW_W:    vw_ff <= csr_wdata[10:0];
            rcw_pkg::CSR_VIEW_H:    vh_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   rcw_ctrl #(.MARCH_STEPS(MARCH_STEPS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .sts(sts), .cmd(cmd), .step_k(k));

   rcw_dp #(.MAP_SIDE(MAP_SIDE)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .step_k(k),
      .column(req.column), .cam_x(cx_ff), .cam_y(cy_ff), .cam_angle(ca_ff),
      .map_bits({mh_ff, ml_ff}), .view_w(vw_ff), .view_h(vh_ff),
      .out_column(rsp.out_column), .wall_code(rsp.wall_code), .span_top(rsp.span_top),
      .span_bottom(rsp.span_bottom), .march_steps(rsp.march_steps));
endmodule
